/* hw/rtl/hhd_pkg.sv */
// shared types and constants for the http audio header detector
// pattern texts, digit phase codes and request structs
// no dependencies
package hhd_pkg;

  localparam int unsigned HistDepth = 23;
  localparam int unsigned TypeLen   = 24;
  localparam int unsigned LenLen    = 16;

  localparam logic [7:0] TypeText [TypeLen] = '{
    8'h43, 8'h6f, 8'h6e, 8'h74, 8'h65, 8'h6e, 8'h74, 8'h2d, 8'h54, 8'h79, 8'h70, 8'h65,
    8'h3a, 8'h20, 8'h61, 8'h75, 8'h64, 8'h69, 8'h6f, 8'h2f, 8'h6d, 8'h70, 8'h65, 8'h67
  };

  localparam logic [7:0] LenText [LenLen] = '{
    8'h43, 8'h6f, 8'h6e, 8'h74, 8'h65, 8'h6e, 8'h74, 8'h2d,
    8'h4c, 8'h65, 8'h6e, 8'h67, 8'h74, 8'h68, 8'h3a, 8'h20
  };

  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharTab   = 8'h09;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;

  localparam logic [1:0] PhIdle   = 2'd0;
  localparam logic [1:0] PhBlank  = 2'd1;
  localparam logic [1:0] PhDigits = 2'd2;
  localparam logic [1:0] PhDone   = 2'd3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } hhd_in_t;

  typedef struct packed {
    logic        found;
    logic [31:0] content_length;
  } hhd_out_t;

  typedef struct packed {
    logic type_hit;
    logic len_hit;
  } hhd_match_t;

  typedef struct packed {
    logic advance;
    logic reported;
    logic last;
  } hhd_win_ctrl_t;

endpackage

/* hw/rtl/hhd_matcher.sv */
// sliding byte window and header text comparators
// depends on hhd_pkg
module hhd_matcher (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  hhd_pkg::hhd_win_ctrl_t ctrl_i,
  input  logic [7:0]            cur_byte_i,
  output hhd_pkg::hhd_match_t   match_o
);

  logic [7:0] win_q [hhd_pkg::HistDepth];
  logic [7:0] win_d [hhd_pkg::HistDepth];
  logic [7:0] view  [hhd_pkg::HistDepth + 1];
  logic       type_ok;
  logic       len_ok;

  always_comb begin
    view[0] = cur_byte_i;
    for (int d = 1; d <= hhd_pkg::HistDepth; d++) begin
      view[d] = win_q[d-1];
    end
  end

  always_comb begin
    type_ok = 1'b1;
    for (int k = 0; k < hhd_pkg::TypeLen; k++) begin
      if (view[hhd_pkg::TypeLen-1-k] != hhd_pkg::TypeText[k]) begin
        type_ok = 1'b0;
      end
    end
    len_ok = 1'b1;
    for (int k = 0; k < hhd_pkg::LenLen; k++) begin
      if (view[hhd_pkg::LenLen-1-k] != hhd_pkg::LenText[k]) begin
        len_ok = 1'b0;
      end
    end
  end

  assign match_o.type_hit = type_ok;
  assign match_o.len_hit  = len_ok;

  always_comb begin
    win_d = win_q;
    if (ctrl_i.advance) begin
      if (ctrl_i.last) begin
        for (int i = 0; i < hhd_pkg::HistDepth; i++) begin
          win_d[i] = 8'h00;
        end
      end else if (!ctrl_i.reported) begin
        win_d[0] = cur_byte_i;
        for (int i = 1; i < hhd_pkg::HistDepth; i++) begin
          win_d[i] = win_q[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < hhd_pkg::HistDepth; i++) begin
        win_q[i] <= 8'h00;
      end
    end else begin
      win_q <= win_d;
    end
  end

endmodule

/* hw/rtl/hhd_parser.sv */
// header flags, length digit parser and result register
// depends on hhd_pkg
module hhd_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  hhd_pkg::hhd_in_t    in_req_i,
  input  hhd_pkg::hhd_match_t match_i,
  output logic                reported_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output hhd_pkg::hhd_out_t   out_req_o
);

  logic              type_seen_q, type_seen_d;
  logic              len_seen_q, len_seen_d;
  logic [1:0]        phase_q, phase_d;
  logic [31:0]       value_q, value_d;
  logic              reported_q, reported_d;
  logic              out_valid_q, out_valid_d;
  hhd_pkg::hhd_out_t out_q, out_d;

  logic        advance;
  logic        is_digit;
  logic        is_blank;
  logic [31:0] acc_base;
  logic [35:0] acc_sum;
  logic [31:0] acc_sat;
  logic        has_result;
  logic        res_found;
  logic [31:0] res_len;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign advance    = in_valid_i && in_ready_o;
  assign reported_o = reported_q;

  assign is_digit = (in_req_i.data_byte >= hhd_pkg::CharZero) &&
                    (in_req_i.data_byte <= hhd_pkg::CharNine);
  assign is_blank = (in_req_i.data_byte == hhd_pkg::CharSpace) ||
                    (in_req_i.data_byte == hhd_pkg::CharTab);

  // first digit restarts the value
  assign acc_base = (phase_q == hhd_pkg::PhBlank) ? 32'd0 : value_q;
  assign acc_sum  = {1'b0, acc_base, 3'b000} + {3'b000, acc_base, 1'b0} +
                    {32'd0, in_req_i.data_byte[3:0]};
  assign acc_sat  = (acc_sum[35:32] != 4'd0) ? 32'hffff_ffff : acc_sum[31:0];

  always_comb begin
    type_seen_d = type_seen_q;
    len_seen_d  = len_seen_q;
    phase_d     = phase_q;
    value_d     = value_q;
    reported_d  = reported_q;
    has_result  = 1'b0;
    res_found   = 1'b0;
    res_len     = 32'd0;

    if (advance && !reported_q) begin
      unique case (phase_q)
        hhd_pkg::PhBlank: begin
          if (is_digit) begin
            value_d = acc_sat;
            phase_d = hhd_pkg::PhDigits;
          end else if (!is_blank) begin
            phase_d = hhd_pkg::PhDone;
          end
        end
        hhd_pkg::PhDigits: begin
          if (is_digit) begin
            value_d = acc_sat;
          end else begin
            phase_d = hhd_pkg::PhDone;
          end
        end
        default: begin
        end
      endcase

      priority if (!type_seen_q && match_i.type_hit) begin
        type_seen_d = 1'b1;
      end else if (!len_seen_q && match_i.len_hit) begin
        len_seen_d = 1'b1;
        phase_d    = hhd_pkg::PhBlank;
        value_d    = 32'd0;
      end else begin
      end

      if (type_seen_d && len_seen_d &&
          (phase_d == hhd_pkg::PhDone || in_req_i.last_byte)) begin
        has_result = 1'b1;
        res_found  = 1'b1;
        res_len    = value_d;
        reported_d = 1'b1;
      end else if (in_req_i.last_byte) begin
        has_result = 1'b1;
      end
    end

    if (advance && in_req_i.last_byte) begin
      type_seen_d = 1'b0;
      len_seen_d  = 1'b0;
      phase_d     = hhd_pkg::PhIdle;
      value_d     = 32'd0;
      reported_d  = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    if (advance && has_result) begin
      out_valid_d          = 1'b1;
      out_d.found          = res_found;
      out_d.content_length = res_len;
    end
  end

  // value is committed before the last-byte clear
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      type_seen_q <= 1'b0;
      len_seen_q  <= 1'b0;
      phase_q     <= hhd_pkg::PhIdle;
      value_q     <= 32'd0;
      reported_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      type_seen_q <= type_seen_d;
      len_seen_q  <= len_seen_d;
      phase_q     <= phase_d;
      value_q     <= value_d;
      reported_q  <= reported_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

endmodule

/* hw/rtl/http_audio_header_detector.sv */
// top level of the http audio header detector
// input register feeding window matcher and length parser
// depends on hhd_pkg, hhd_matcher, hhd_parser
//
// usage
//   in channel: one payload byte per request, with last_byte on the final
//   byte of a packet payload. out channel: at most one request per payload,
//   found plus content_length (zero when not found).
//   a request is given as soon as both headers are seen and the digit run
//   after the length header ends, or at the last byte if none was given yet.
//   bytes after a report are consumed silently until the last byte.
// timing
//   one byte accepted per cycle while the receiver takes results; a result
//   passes the input register and then the output register.
//   throughput is set by the combinational compare and digit accumulate path.
// reset and stall
//   reset clears the window, header flags and the valid bits of both register stages.
//   while the receiver stalls the result is held; the input register still
//   takes one more byte if empty, then in_ready_o drops until the result is taken.
module http_audio_header_detector (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  hhd_pkg::hhd_in_t  in_req_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output hhd_pkg::hhd_out_t out_req_o
);

  logic                   s1_valid_q, s1_valid_d;
  hhd_pkg::hhd_in_t       s1_q;
  logic                   p_ready;
  logic                   p_reported;
  logic                   advance;
  hhd_pkg::hhd_match_t    match;
  hhd_pkg::hhd_win_ctrl_t win_ctrl;

  assign advance    = s1_valid_q && p_ready;
  assign in_ready_o = !s1_valid_q || p_ready;

  always_comb begin
    s1_valid_d = s1_valid_q && !advance;
    if (in_valid_i && in_ready_o) begin
      s1_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_q <= in_req_i;
    end
  end

  assign win_ctrl.advance  = advance;
  assign win_ctrl.reported = p_reported;
  assign win_ctrl.last     = s1_q.last_byte;

  hhd_matcher u_matcher (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (win_ctrl),
    .cur_byte_i (s1_q.data_byte),
    .match_o    (match)
  );

  hhd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s1_valid_q),
    .in_ready_o  (p_ready),
    .in_req_i    (s1_q),
    .match_i     (match),
    .reported_o  (p_reported),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_req_o   (out_req_o)
  );

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps
// testbench for http_audio_header_detector: payload bytes go in with random idling on
// both sides, and each report is checked against a byte-level model kept here
// depends on hhd_pkg and the detector rtl

class hdr_report_board;
  string             type_hdr;
  string             len_hdr;
  logic [7:0]        window [23];
  bit                type_found;
  bit                len_hdr_seen;
  bit                report_given;
  logic [1:0]        phase;
  logic [31:0]       length_acc;
  hhd_pkg::hhd_out_t reports_due [$];
  int                errors;
  int                bytes_accepted;
  int                bytes_inspected;
  int                found_count;
  int                miss_count;

  function new(string t, string l);
    type_hdr = t;
    len_hdr = l;
    clear_state();
  endfunction

  function void clear_state();
    foreach (window[i]) window[i] = 8'h00;
    type_found = 1'b0;
    len_hdr_seen = 1'b0;
    report_given = 1'b0;
    phase = hhd_pkg::PhIdle;
    length_acc = '0;
  endfunction

  function bit tail_matches(string pat, logic [7:0] cur);
    int n;
    int k;
    logic [7:0] seen;
    n = pat.len();
    for (k = 0; k < n; k++) begin
      seen = (k == n - 1) ? cur : window[n - 2 - k];
      if (seen != pat[k]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function void push_digit(logic [7:0] b);
    longint unsigned acc;
    acc = length_acc;
    acc = acc * 10 + (b - hhd_pkg::CharZero);
    length_acc = (acc > 64'hffff_ffff) ? 32'hffff_ffff : acc[31:0];
  endfunction

  function int pending();
    return reports_due.size();
  endfunction

  // accepted request on the input side
  function void note_byte(hhd_pkg::hhd_in_t req);
    logic [7:0] b;
    bit last;
    bit is_digit;
    int i;
    hhd_pkg::hhd_out_t due;
    b = req.data_byte;
    last = req.last_byte;
    is_digit = (b >= hhd_pkg::CharZero) && (b <= hhd_pkg::CharNine);
    bytes_accepted++;
    if (report_given) begin
      if (last) clear_state();
      return;
    end
    bytes_inspected++;
    if (phase == hhd_pkg::PhBlank) begin
      if (is_digit) begin
        length_acc = '0;
        push_digit(b);
        phase = hhd_pkg::PhDigits;
      end else if (b != hhd_pkg::CharSpace && b != hhd_pkg::CharTab) begin
        phase = hhd_pkg::PhDone;
      end
    end else if (phase == hhd_pkg::PhDigits) begin
      if (is_digit) push_digit(b);
      else phase = hhd_pkg::PhDone;
    end
    if (!type_found && tail_matches(type_hdr, b)) begin
      type_found = 1'b1;
    end else if (!len_hdr_seen && tail_matches(len_hdr, b)) begin
      len_hdr_seen = 1'b1;
      phase = hhd_pkg::PhBlank;
      length_acc = '0;
    end
    if (type_found && len_hdr_seen && (phase == hhd_pkg::PhDone || last)) begin
      due.found = 1'b1;
      due.content_length = length_acc;
      reports_due.push_back(due);
      report_given = 1'b1;
    end else if (last) begin
      due = '0;
      reports_due.push_back(due);
    end
    if (last) begin
      clear_state();
    end else begin
      for (i = 22; i > 0; i--) window[i] = window[i - 1];
      window[0] = b;
    end
  endfunction

  // accepted request on the output side
  function void check_report(hhd_pkg::hhd_out_t got);
    hhd_pkg::hhd_out_t want;
    if (reports_due.size() == 0) begin
      errors++;
      $display("%0t: unexpected report, expected none, got found=%0b length=%0d",
               $time, got.found, got.content_length);
      return;
    end
    want = reports_due.pop_front();
    if (got.found !== want.found) begin
      errors++;
      $display("%0t: found mismatch, expected %0b, got %0b", $time, want.found, got.found);
    end
    if (got.content_length !== want.content_length) begin
      errors++;
      $display("%0t: content_length mismatch, expected %0d, got %0d",
               $time, want.content_length, got.content_length);
    end
    if (want.found) found_count++;
    else miss_count++;
  endfunction
endclass

module testbench;
  localparam int CycleLimit  = 400000;
  localparam int RandomBytes = 1000;
  localparam logic [7:0] CharCr = 8'h0d;
  localparam logic [7:0] CharLf = 8'h0a;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  hhd_pkg::hhd_in_t  in_req_i;
  logic              out_valid_o;
  logic              out_ready_i;
  hhd_pkg::hhd_out_t out_req_o;

  string             type_hdr = "Content-Type: audio/mpeg";
  string             len_hdr = "Content-Length: ";
  hdr_report_board   board;
  logic [7:0]        pkt_bytes [$];
  int                packets_sent;
  int                send_idle_pct;
  int                recv_stall_pct;
  bit                hold_req;
  int                cycle_count;

  http_audio_header_detector uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_req_o  (out_req_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) board.note_byte(in_req_i);
      if (out_valid_o && out_ready_i) board.check_report(out_req_o);
    end
  end

  // output side: random stalls plus one long hold on request
  initial begin
    int hold_left;
    hold_left = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  function automatic void add_byte(logic [7:0] b);
    pkt_bytes.push_back(b);
  endfunction

  function automatic void add_text(string s);
    int i;
    for (i = 0; i < s.len(); i++) pkt_bytes.push_back(s[i]);
  endfunction

  function automatic void add_crlf();
    pkt_bytes.push_back(CharCr);
    pkt_bytes.push_back(CharLf);
  endfunction

  function automatic void add_random(int n, int lo, int hi);
    repeat (n) pkt_bytes.push_back(8'($urandom_range(hi, lo)));
  endfunction

  function automatic void corrupt_tail(int n);
    int idx;
    idx = pkt_bytes.size() - 1 - $urandom_range(n - 1);
    pkt_bytes[idx] = pkt_bytes[idx] ^ 8'(8'h01 << $urandom_range(7));
  endfunction

  function automatic void add_type_field();
    add_text(type_hdr);
    if ($urandom_range(9) == 0) corrupt_tail(24);
    add_crlf();
  endfunction

  function automatic void add_len_field();
    int n;
    add_text(len_hdr);
    if ($urandom_range(11) == 0) corrupt_tail(16);
    n = $urandom_range(3);
    repeat (n) add_byte($urandom_range(1) ? hhd_pkg::CharSpace : hhd_pkg::CharTab);
    if ($urandom_range(15) == 0) add_byte("+");
    case ($urandom_range(9))
      0: n = 0;
      1: n = $urandom_range(14, 10);
      default: n = $urandom_range(6, 1);
    endcase
    repeat (n) add_byte(8'(hhd_pkg::CharZero + $urandom_range(9)));
    case ($urandom_range(4))
      0: ;
      1: add_byte(";");
      2: add_byte(hhd_pkg::CharSpace);
      default: add_crlf();
    endcase
  endfunction

  function automatic void build_response();
    bit with_type;
    bit with_len;
    bit len_first;
    case ($urandom_range(3))
      0: begin
        add_text("HTTP/1.1 200 OK");
        add_crlf();
      end
      1: add_random($urandom_range(6, 1), 32, 126);
      default: ;
    endcase
    with_type = ($urandom_range(7) != 0);
    with_len = ($urandom_range(7) != 0);
    len_first = $urandom_range(1);
    if (with_len && len_first) add_len_field();
    if (with_type) add_type_field();
    if ($urandom_range(3) == 0) begin
      add_text("Server: x");
      add_crlf();
    end
    if (with_len && !len_first) add_len_field();
    if ($urandom_range(7) == 0) add_type_field();
    add_crlf();
    add_random($urandom_range(8), 0, 255);
  endfunction

  // one request, held until accepted; returns at the falling edge
  task automatic offer_byte(logic [7:0] b, logic last);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i <= '{data_byte: b, last_byte: last};
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic send_part(int n);
    int i;
    logic [7:0] b;
    for (i = 0; i < n; i++) begin
      b = pkt_bytes.pop_front();
      offer_byte(b, i == n - 1);
    end
    packets_sent++;
  endtask

  task automatic send_packet();
    send_part(pkt_bytes.size());
  endtask

  task automatic random_packet();
    int cut;
    case ($urandom_range(9))
      0, 1: begin
        add_random($urandom_range(12, 1), 0, 255);
        send_packet();
      end
      2: begin
        build_response();
        cut = $urandom_range(pkt_bytes.size(), 1);
        while (pkt_bytes.size() > cut) void'(pkt_bytes.pop_back());
        send_packet();
      end
      3: begin
        build_response();
        cut = $urandom_range(pkt_bytes.size() - 1, 1);
        send_part(cut);
        send_packet();
      end
      default: begin
        build_response();
        send_packet();
      end
    endcase
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  initial begin
    int ph;
    int start_bytes;
    int start_pk;
    bit held;
    board = new(type_hdr, len_hdr);
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_req_i = '0;
    hold_req = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    packets_sent = 0;
    cycle_count = 0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed packets
    add_byte(8'h00);
    send_packet();
    add_byte(8'hff);
    send_packet();
    add_text(type_hdr); add_crlf(); add_text(len_hdr); add_text("1234"); add_crlf();
    add_text("body");
    send_packet();
    // length first, type completes the report
    add_text(len_hdr); add_text("42"); add_crlf(); add_text(type_hdr); add_crlf();
    send_packet();
    // no digits
    add_text(type_hdr); add_crlf(); add_text(len_hdr); add_crlf();
    send_packet();
    // blanks and tabs before digits
    add_text(type_hdr); add_crlf(); add_text(len_hdr); add_text("\t \t 99x");
    send_packet();
    add_text(type_hdr); add_crlf(); add_text(len_hdr); add_text("4294967295;");
    send_packet();
    add_text(len_hdr); add_text("4294967296 "); add_text(type_hdr); add_crlf();
    send_packet();
    // saturation, payload ends on a digit
    add_text(type_hdr); add_crlf(); add_text(len_hdr); add_text("12345678901234567890");
    send_packet();
    add_text(type_hdr); add_crlf(); add_text(len_hdr); add_text("77");
    send_packet();
    // payload ends during blanks
    add_text(type_hdr); add_crlf(); add_text(len_hdr); add_text(" ");
    send_packet();
    add_text(len_hdr); add_text("5"); add_crlf();
    send_packet();
    add_text(type_hdr); add_crlf();
    send_packet();
    // wrong case
    add_text("content-type: audio/mpeg"); add_crlf(); add_text(len_hdr); add_text("9");
    add_crlf();
    send_packet();
    // header split over two payloads
    add_text("Content-Type: aud");
    send_packet();
    add_text("io/mpeg"); add_crlf(); add_text(len_hdr); add_text("3"); add_crlf();
    send_packet();
    // repeated length header
    add_text(len_hdr); add_text("5 "); add_text(len_hdr); add_text("6 "); add_text(type_hdr);
    add_crlf();
    send_packet();
    // sign before digits
    add_text(type_hdr); add_crlf(); add_text(len_hdr); add_text("-12"); add_crlf();
    send_packet();
    // headers after a report are ignored
    add_text(type_hdr); add_crlf(); add_text(len_hdr); add_text("8;"); add_text(type_hdr);
    add_text(len_hdr); add_text("9;x");
    send_packet();
    // digit boundary characters
    add_text(type_hdr); add_crlf(); add_text(len_hdr); add_text("/");
    send_packet();
    add_text(type_hdr); add_crlf(); add_text(len_hdr); add_text("9:");
    send_packet();
    // report and last byte together
    add_text(len_hdr); add_text("6;"); add_text(type_hdr);
    send_packet();
    drain();

    // random traffic under four idle mixes
    start_bytes = board.bytes_accepted;
    start_pk = packets_sent;
    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
        default: begin send_idle_pct = 22; recv_stall_pct = 22; end
      endcase
      held = 1'b0;
      while (board.bytes_accepted - start_bytes < RandomBytes * (ph + 1) / 4 ||
             packets_sent - start_pk < 3 * (ph + 1)) begin
        if (ph == 0 && !held && board.bytes_accepted - start_bytes > RandomBytes / 16) begin
          hold_req = 1'b1;
          held = 1'b1;
        end
        random_packet();
      end
      drain();
    end

    repeat (10) @(posedge clk_i);
    $display("covered %0d inspected bytes (%0d accepted) in %0d payloads",
             board.bytes_inspected, board.bytes_accepted, packets_sent);
    $display("checked %0d reports with found set and %0d without, %0d errors",
             board.found_count, board.miss_count, board.errors + board.pending());
    if (board.errors == 0 && board.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
